/* rtl/time_window_iterator_macros.svh */
// assertion macros shared by the time window iterator rtl
`ifndef TIME_WINDOW_ITERATOR_MACROS_SVH
`define TIME_WINDOW_ITERATOR_MACROS_SVH

`ifndef ASSERT_OFF
// property checked on every clock edge outside reset
`define TWI_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// property checked on every clock edge, reset included
`define TWI_ASSERT_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define TWI_ASSERT(lbl, clk, rst_n, prop, msg)
`define TWI_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

/* rtl/twi_pkg.sv */
// types, codes and helpers for the time window iterator
`timescale 1ns / 1ps
`default_nettype none

package twi_pkg;

	localparam int DATA_W = 48;
	// two guard bits keep differences of 48-bit values exact
	localparam int EXT_W  = 50;

	localparam logic [1:0] OP_ADD_RANGE     = 2'd0;
	localparam logic [1:0] OP_RESET_CURSORS = 2'd1;
	localparam logic [1:0] OP_NEXT_WINDOW   = 2'd2;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_INVALID = 2'd1;
	localparam logic [1:0] ST_FULL    = 2'd2;

	typedef enum logic {
		ALU_ADD,
		ALU_SUB
	} alu_op_t;

	typedef struct packed {
		logic [1:0]               op;
		logic signed [DATA_W-1:0] range_start;
		logic signed [DATA_W-1:0] range_end;
		logic signed [DATA_W-1:0] step_size;
		logic signed [DATA_W-1:0] now_time;
	} in_item_t;

	typedef struct packed {
		logic [1:0]               status;
		logic                     window_valid;
		logic signed [DATA_W-1:0] window_start;
		logic signed [DATA_W-1:0] window_end;
	} out_item_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] rng_start;
		logic signed [DATA_W-1:0] rng_end;
		logic signed [DATA_W-1:0] rng_step;
	} range_t;

	function automatic logic signed [EXT_W-1:0] sext(input logic [DATA_W-1:0] v);
		return {{(EXT_W - DATA_W){v[DATA_W-1]}}, v};
	endfunction

endpackage

`default_nettype wire

/* rtl/twi_channels.sv */
// valid/ready channel interfaces for command and result transactions
`timescale 1ns / 1ps
`default_nettype none

interface twi_cmd_if;
	logic              valid;
	logic              ready;
	twi_pkg::in_item_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

interface twi_res_if;
	logic               valid;
	logic               ready;
	twi_pkg::out_item_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

/* rtl/twi_ram.sv */
// generic single write port ram with registered read
`timescale 1ns / 1ps
`default_nettype none

module twi_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                                   clk,
	input  wire logic                                   we,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                       wdata,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                            rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

/* rtl/twi_alu.sv */
// shared add/subtract unit on sign-extended operands
`timescale 1ns / 1ps
`default_nettype none

module twi_alu (
	input  wire twi_pkg::alu_op_t                     op,
	input  wire logic signed [twi_pkg::EXT_W-1:0]     a,
	input  wire logic signed [twi_pkg::EXT_W-1:0]     b,
	output logic signed [twi_pkg::EXT_W-1:0]          y
);

	logic                         sub;
	logic [twi_pkg::EXT_W-1:0]    b_inv;

	assign sub   = (op == twi_pkg::ALU_SUB);
	// one adder: subtraction by inverting b and carrying in
	assign b_inv = b ^ {twi_pkg::EXT_W{sub}};
	assign y     = a + b_inv + twi_pkg::EXT_W'(sub);

endmodule

`default_nettype wire

/* rtl/time_window_iterator.sv */
// time window iterator: range table, cursor walk and window generation
// one item at a time; cmd.ready is high only while idle, again as each result goes valid
// add: through add0 and add1 to done, straight from add0 to done when rejected early
// next: read, two checks, advance and end; exhausted ranges skipped, read ends a done walk
// reset cursors: per range held a read and a write reload the cursor with the range start
// arst_n clears range count, walk position and handshakes; the tables come up unknown
`timescale 1ns / 1ps
`default_nettype none
`include "time_window_iterator_macros.svh"

module time_window_iterator #(
	parameter int MAX_NODES = 16
) (
	input  wire logic clk,
	input  wire logic arst_n,
	twi_cmd_if.sink   cmd,
	twi_res_if.source res
);

	localparam int CntW  = $clog2(MAX_NODES + 1);
	localparam int IdxW  = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
	localparam int RngW  = $bits(twi_pkg::range_t);
	localparam int DW    = twi_pkg::DATA_W;
	localparam int EW    = twi_pkg::EXT_W;

	typedef enum logic [3:0] {
		S_IDLE,
		S_ADD0,
		S_ADD1,
		S_CLR_RD,
		S_CLR_WR,
		S_NX_RD,
		S_NX_C1,
		S_NX_C2,
		S_NX_ADV,
		S_NX_END,
		S_DONE
	} state_t;

	state_t                 state_q;
	twi_pkg::in_item_t      item_q;
	logic [CntW-1:0]        cnt_q;
	logic [CntW-1:0]        cur_q;
	logic [CntW-1:0]        idx_q;
	logic signed [DW-1:0]   last_end_q;
	logic signed [EW-1:0]   t_q;
	logic [1:0]             sts_q;
	logic                   wv_q;
	logic signed [DW-1:0]   ws_q;
	logic signed [DW-1:0]   we_q;
	twi_pkg::out_item_t     out_q;
	logic                   out_vld_q;

	twi_pkg::alu_op_t       alu_op;
	logic signed [EW-1:0]   alu_a;
	logic signed [EW-1:0]   alu_b;
	logic signed [EW-1:0]   alu_y;
	logic                   alu_neg;

	logic                   rng_we;
	logic [IdxW-1:0]        raddr;
	logic [RngW-1:0]        rng_rdata;
	twi_pkg::range_t        rng_rd;
	twi_pkg::range_t        rng_wr;
	logic                   cur_we;
	logic [IdxW-1:0]        cur_waddr;
	logic [DW-1:0]          cur_wdata;
	logic [DW-1:0]          cur_rdata;

	logic                   add_bad;
	logic                   add_full;
	logic                   cmd_xfer;
	logic                   out_free;

	assign cmd_xfer  = cmd.valid && cmd.ready;
	assign cmd.ready = (state_q == S_IDLE);
	assign res.valid = out_vld_q;
	assign res.data  = out_q;
	assign out_free  = !out_vld_q || res.ready;

	assign rng_rd = twi_pkg::range_t'(rng_rdata);
	assign alu_neg = alu_y[EW-1];

	// add checks once the span minus step is on the alu
	assign add_bad  = alu_neg ||
		((cnt_q != '0) && (last_end_q != item_q.range_start));
	assign add_full = (cnt_q == CntW'(MAX_NODES));

	// operand selection for the shared unit
	always_comb begin
		alu_op = twi_pkg::ALU_SUB;
		alu_a  = '0;
		alu_b  = '0;
		unique case (state_q)
			S_ADD0: begin
				alu_a = twi_pkg::sext(item_q.range_end);
				alu_b = twi_pkg::sext(item_q.range_start);
			end
			S_ADD1: begin
				alu_a = t_q;
				alu_b = twi_pkg::sext(item_q.step_size);
			end
			S_NX_C1: begin
				alu_a = twi_pkg::sext(cur_rdata);
				alu_b = twi_pkg::sext(rng_rd.rng_end);
			end
			S_NX_C2: begin
				alu_a = twi_pkg::sext(item_q.now_time);
				alu_b = twi_pkg::sext(cur_rdata);
			end
			S_NX_ADV: begin
				alu_op = twi_pkg::ALU_ADD;
				alu_a  = twi_pkg::sext(cur_rdata);
				alu_b  = twi_pkg::sext(rng_rd.rng_step);
			end
			S_NX_END: begin
				alu_a = twi_pkg::sext(item_q.now_time);
				alu_b = t_q;
			end
			default: begin
			end
		endcase
	end

	twi_alu u_alu (
		.op (alu_op),
		.a  (alu_a),
		.b  (alu_b),
		.y  (alu_y)
	);

	// table ports
	assign raddr = (item_q.op == twi_pkg::OP_RESET_CURSORS) ? idx_q[IdxW-1:0]
		: cur_q[IdxW-1:0];
	assign rng_we = (state_q == S_ADD1) && !add_bad && !add_full;
	assign rng_wr = '{rng_start: item_q.range_start, rng_end: item_q.range_end,
		rng_step: item_q.step_size};

	always_comb begin
		cur_we    = rng_we;
		cur_waddr = cnt_q[IdxW-1:0];
		cur_wdata = item_q.range_start;
		if (state_q == S_CLR_WR) begin
			cur_we    = 1'b1;
			cur_waddr = idx_q[IdxW-1:0];
			cur_wdata = rng_rd.rng_start;
		end else if (state_q == S_NX_ADV) begin
			cur_we    = 1'b1;
			cur_waddr = cur_q[IdxW-1:0];
			cur_wdata = alu_y[DW-1:0];
		end
	end

	twi_ram #(
		.WIDTH (RngW),
		.DEPTH (MAX_NODES)
	) u_rng_ram (
		.clk   (clk),
		.we    (rng_we),
		.waddr (cnt_q[IdxW-1:0]),
		.wdata (rng_wr),
		.raddr (raddr),
		.rdata (rng_rdata)
	);

	twi_ram #(
		.WIDTH (DW),
		.DEPTH (MAX_NODES)
	) u_cur_ram (
		.clk   (clk),
		.we    (cur_we),
		.waddr (cur_waddr),
		.wdata (cur_wdata),
		.raddr (raddr),
		.rdata (cur_rdata)
	);

	// sequencer, result registers and output stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			cnt_q     <= '0;
			cur_q     <= '0;
			idx_q     <= '0;
			out_vld_q <= 1'b0;
		end else begin
			// the done state reloads the output stage itself
			if (res.ready && state_q != S_DONE) begin
				out_vld_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (cmd_xfer) begin
						item_q <= cmd.data;
						sts_q  <= twi_pkg::ST_OK;
						wv_q   <= 1'b0;
						ws_q   <= '0;
						we_q   <= '0;
						case (cmd.data.op)
							twi_pkg::OP_ADD_RANGE: begin
								state_q <= S_ADD0;
							end
							twi_pkg::OP_RESET_CURSORS: begin
								cur_q   <= '0;
								idx_q   <= '0;
								state_q <= S_CLR_RD;
							end
							twi_pkg::OP_NEXT_WINDOW: begin
								state_q <= S_NX_RD;
							end
							default: begin
								state_q <= S_DONE;
							end
						endcase
					end
				end
				S_ADD0: begin
					if (item_q.range_end[DW-1] || alu_neg) begin
						sts_q   <= twi_pkg::ST_INVALID;
						state_q <= S_DONE;
					end else begin
						t_q     <= alu_y;
						state_q <= S_ADD1;
					end
				end
				S_ADD1: begin
					if (add_bad) begin
						sts_q <= twi_pkg::ST_INVALID;
					end else if (add_full) begin
						sts_q <= twi_pkg::ST_FULL;
					end else begin
						cnt_q      <= cnt_q + CntW'(1);
						last_end_q <= item_q.range_end;
					end
					state_q <= S_DONE;
				end
				S_CLR_RD: begin
					state_q <= (idx_q == cnt_q) ? S_DONE : S_CLR_WR;
				end
				S_CLR_WR: begin
					idx_q   <= idx_q + CntW'(1);
					state_q <= S_CLR_RD;
				end
				S_NX_RD: begin
					state_q <= (cur_q < cnt_q) ? S_NX_C1 : S_DONE;
				end
				S_NX_C1: begin
					// cursor at or past the range end
					if (!alu_neg) begin
						cur_q   <= cur_q + CntW'(1);
						state_q <= S_NX_RD;
					end else begin
						state_q <= S_NX_C2;
					end
				end
				S_NX_C2: begin
					// cursor later than now
					if (alu_neg) begin
						cur_q   <= cur_q + CntW'(1);
						state_q <= S_NX_RD;
					end else begin
						ws_q    <= alu_y[DW-1:0];
						state_q <= S_NX_ADV;
					end
				end
				S_NX_ADV: begin
					t_q     <= twi_pkg::sext(alu_y[DW-1:0]);
					state_q <= S_NX_END;
				end
				S_NX_END: begin
					wv_q    <= 1'b1;
					// advanced cursor negative or beyond now gives a zero end
					we_q    <= (t_q[EW-1] || alu_neg) ? '0 : alu_y[DW-1:0];
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (out_free) begin
						out_q     <= '{status: sts_q, window_valid: wv_q,
							window_start: ws_q, window_end: we_q};
						out_vld_q <= 1'b1;
						state_q   <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	`TWI_ASSERT(a_cur_le_cnt, clk, arst_n, cur_q <= cnt_q, "walk position beyond range count")
	`TWI_ASSERT(a_cnt_le_max, clk, arst_n, cnt_q <= CntW'(MAX_NODES), "range count overflow")
	`TWI_ASSERT(a_busy_after_cmd, clk, arst_n, cmd_xfer |=> !cmd.ready, "ready after accept")
	`TWI_ASSERT(a_window_ok, clk, arst_n, (res.valid && res.data.window_valid) |-> (res.data.status == twi_pkg::ST_OK), "window with bad status")
	`TWI_ASSERT(a_add_room, clk, arst_n, rng_we |-> (cnt_q < CntW'(MAX_NODES)), "range write into full table")
	`TWI_ASSERT_ALWAYS(a_rst_idle, clk, !arst_n |=> !res.valid, "result valid out of reset")

endmodule

`default_nettype wire
